/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* sv/ptl_pkg.sv */
// ----------------------------------------------------------------------------
// ptl_pkg
// shared types and codes for the prefix trie lookup block
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

  localparam int COUNT_BITS  = 15;
  localparam int INDEX_BITS  = 14;
  localparam int REC_IN_BITS = 24;
  localparam int OFFSET_BITS = 24;
  localparam int STATUS_BITS = 2;

  // gap between node section and data section
  localparam logic [OFFSET_BITS-1:0] SEPARATOR_LEN = OFFSET_BITS'(16);

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_FOUND     = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EXHAUSTED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } walk_state_t;

endpackage

`default_nettype wire

/* sv/ptl_node_ram.sv */
// ----------------------------------------------------------------------------
// ptl_node_ram
// single-port node memory, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_node_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 48
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* sv/ip_prefix_trie_lookup.sv */
// ----------------------------------------------------------------------------
// ip_prefix_trie_lookup
// binary trie walk over a 128-bit address, one node read per address bit
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | start, busy         | in_kind, in_node_index, in_left_record,
//           |                     | in_right_record, in_address_high/low
//  result   | out_valid (strobe)  | out_status, out_data_offset
//  config   | cfg_wr_en           | cfg_wr_data (tree size)
//
//  a write item is stored at acceptance and leaves busy low
//  a lookup keeps busy high while it reads nodes (1..ADDRESS_BITS nodes),
//  one node memory read per address bit; result strobes as busy drops
//  sync reset clears control, sets tree size to one; node memory is not cleared
//  the receiver cannot stall; each result shows for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ip_prefix_trie_lookup
  import ptl_pkg::*;
#(
  parameter int NODE_DEPTH   = 16384,
  parameter int RECORD_BITS  = 24,
  parameter int ADDRESS_BITS = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_kind,
  input  wire logic [INDEX_BITS-1:0]  in_node_index,
  input  wire logic [REC_IN_BITS-1:0] in_left_record,
  input  wire logic [REC_IN_BITS-1:0] in_right_record,
  input  wire logic [63:0]            in_address_high,
  input  wire logic [63:0]            in_address_low,
  output logic                        out_valid,
  output logic [STATUS_BITS-1:0]      out_status,
  output logic [OFFSET_BITS-1:0]      out_data_offset,
  input  wire logic                   cfg_wr_en,
  input  wire logic [COUNT_BITS-1:0]  cfg_wr_data
);

  localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int DW = 2 * RECORD_BITS;
  localparam int SW = $clog2(ADDRESS_BITS + 1);
  localparam logic [RECORD_BITS:0] DEPTH_C = (RECORD_BITS + 1)'(NODE_DEPTH);

  walk_state_t              state_r, state_nxt;
  logic [COUNT_BITS-1:0]    tree_size_r;
  logic [ADDRESS_BITS-1:0]  addr_r, addr_nxt;
  logic [SW-1:0]            cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0]   out_status_r, out_status_nxt;
  logic [OFFSET_BITS-1:0]   out_offset_r, out_offset_nxt;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_addr;
  logic [DW-1:0]            ram_wdata, ram_rdata;

  logic                     accept;
  logic [RECORD_BITS-1:0]   rec;
  logic [RECORD_BITS-1:0]   count_ext;
  logic [OFFSET_BITS-1:0]   offset;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign rec       = addr_r[ADDRESS_BITS-1] ? ram_rdata[DW-1:RECORD_BITS]
                                            : ram_rdata[RECORD_BITS-1:0];
  assign count_ext = RECORD_BITS'(tree_size_r);
  assign offset    = rec[OFFSET_BITS-1:0] - OFFSET_BITS'(tree_size_r) - SEPARATOR_LEN;
  assign ram_wdata = {RECORD_BITS'(in_right_record), RECORD_BITS'(in_left_record)};

  ptl_node_ram #(
    .DEPTH (NODE_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_WRITE)) begin
          // writes past the end of the store are dropped
          ram_we   = (32'(in_node_index) < 32'(NODE_DEPTH));
          ram_addr = AW'(in_node_index);
        end else if (accept && (in_kind == KIND_LOOKUP)) begin
          ram_re    = 1'b1;
          ram_addr  = '0;
          addr_nxt  = ADDRESS_BITS'({in_address_high, in_address_low});
          cnt_nxt   = SW'(ADDRESS_BITS);
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        priority if (rec == count_ext) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_EMPTY;
          out_offset_nxt = '0;
          state_nxt      = ST_IDLE;
        end else if (rec > count_ext) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_FOUND;
          out_offset_nxt = offset;
          state_nxt      = ST_IDLE;
        end else if (cnt_r == SW'(1)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_EXHAUSTED;
          out_offset_nxt = '0;
          state_nxt      = ST_IDLE;
        end else if ({1'b0, rec} >= DEPTH_C) begin
          // next node lies beyond the store
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_EMPTY;
          out_offset_nxt = '0;
          state_nxt      = ST_IDLE;
        end else begin
          ram_re   = 1'b1;
          ram_addr = AW'(rec);
          addr_nxt = {addr_r[ADDRESS_BITS-2:0], 1'b0};
          cnt_nxt  = cnt_r - SW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tree_size_r <= COUNT_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tree_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_offset = out_offset_r;

endmodule

`default_nettype wire

/* sv/ptl_checker.sv */
// ----------------------------------------------------------------------------
// ptl_checker
// port-level checks on item acceptance and result timing
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptl_checker
  import ptl_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   in_kind,
  input wire logic                   out_valid,
  input wire logic [STATUS_BITS-1:0] out_status,
  input wire logic [OFFSET_BITS-1:0] out_data_offset
);

  logic take_lookup, take_write;

  assign take_lookup = start && !busy && (in_kind == KIND_LOOKUP);
  assign take_write  = start && !busy && (in_kind == KIND_WRITE);

  // a lookup always reads at least one node
  `ASSERT_NEXT(a_lookup_busy, clk, rst_n, take_lookup, busy)

  // a write item finishes at once and gives no result
  `ASSERT_NEXT(a_write_quiet, clk, rst_n, take_write, !busy && !out_valid)

  // the result strobe comes as the walk ends
  `ASSERT_IMPLY(a_result_idle, clk, rst_n, out_valid, !busy && $past(busy))

  // no offset unless data was found
  `ASSERT_IMPLY(a_offset_zero, clk, rst_n, out_valid && (out_status != STATUS_FOUND),
    out_data_offset == '0)

endmodule

bind ip_prefix_trie_lookup ptl_checker u_ptl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_data_offset (out_data_offset)
);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the prefix trie lookup against its own copy of the node store and
// tree size. Small trees are built over a set of written nodes, then walked
// with random, IPv4-mapped, sparse and dense addresses. The input side runs
// in bursts with gaps between them.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ptl_pkg::*;

  localparam int NODE_DEPTH     = 16384;
  localparam int ADDR_BITS      = 128;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 140;

  typedef struct packed {
    logic                   kind;
    logic [INDEX_BITS-1:0]  node_index;
    logic [REC_IN_BITS-1:0] left_rec;
    logic [REC_IN_BITS-1:0] right_rec;
    logic [63:0]            addr_hi;
    logic [63:0]            addr_lo;
  } trie_cmd_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [OFFSET_BITS-1:0] offset;
  } lookup_res_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_kind;
  logic [INDEX_BITS-1:0]  in_node_index;
  logic [REC_IN_BITS-1:0] in_left_record;
  logic [REC_IN_BITS-1:0] in_right_record;
  logic [63:0]            in_address_high;
  logic [63:0]            in_address_low;
  logic                   out_valid;
  logic [STATUS_BITS-1:0] out_status;
  logic [OFFSET_BITS-1:0] out_data_offset;
  logic                   cfg_wr_en;
  logic [COUNT_BITS-1:0]  cfg_wr_data;

  // predicted state of the block
  logic [REC_IN_BITS-1:0] left_mem  [NODE_DEPTH];
  logic [REC_IN_BITS-1:0] right_mem [NODE_DEPTH];
  int node_cnt = 1;

  trie_cmd_t   cmd_q[$];
  lookup_res_t result_q[$];

  // nodes the current tree may reach
  int pool_q[$];
  bit in_pool [NODE_DEPTH];

  bit taken = 1'b0;
  int burst_left = 8;
  int gap_left = 0;
  int idle_cycles = 0;
  int fail_cnt = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int n_found = 0;
  int n_empty = 0;
  int n_exhausted = 0;
  int n_settings = 0;

  ip_prefix_trie_lookup i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_node_index   (in_node_index),
    .in_left_record  (in_left_record),
    .in_right_record (in_right_record),
    .in_address_high (in_address_high),
    .in_address_low  (in_address_low),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_offset (out_data_offset),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lookup_res_t walk_trie(input logic [63:0] hi, input logic [63:0] lo);
    lookup_res_t res;
    logic [ADDR_BITS-1:0] addr;
    int node;
    int rec;
    res.status = STATUS_EXHAUSTED;
    res.offset = '0;
    addr = {hi, lo};
    node = 0;
    for (int bit_no = 0; bit_no < ADDR_BITS; bit_no++) begin
      if (node >= NODE_DEPTH) begin
        res.status = STATUS_EMPTY;
        break;
      end
      rec = addr[ADDR_BITS-1-bit_no] ? int'(right_mem[node]) : int'(left_mem[node]);
      if (rec == node_cnt) begin
        res.status = STATUS_EMPTY;
        break;
      end
      if (rec > node_cnt) begin
        res.status = STATUS_FOUND;
        res.offset = OFFSET_BITS'(rec - node_cnt - int'(SEPARATOR_LEN));
        break;
      end
      node = rec;
    end
    return res;
  endfunction

  // record that keeps the walk inside the written nodes or ends it
  function automatic logic [REC_IN_BITS-1:0] pick_record(input int n, input int p_next);
    int roll;
    roll = $urandom_range(0, 99);
    if (n > 0 && roll < p_next) return REC_IN_BITS'(pool_q[$urandom_range(0, pool_q.size() - 1)]);
    roll = $urandom_range(0, 9);
    if (roll < 3) return REC_IN_BITS'(n);
    if (roll < 5 && n > NODE_DEPTH) return REC_IN_BITS'($urandom_range(NODE_DEPTH, n - 1));
    case (roll)
      5: return REC_IN_BITS'(n + 1);
      6: return REC_IN_BITS'(n + 16);
      7: return REC_IN_BITS'(n + 17);
      8: return '1;
      default: return REC_IN_BITS'($urandom_range(n + 1, 24'hFF_FFFF));
    endcase
  endfunction

  task automatic push_write(input int idx, input logic [REC_IN_BITS-1:0] l,
                            input logic [REC_IN_BITS-1:0] r);
    trie_cmd_t c;
    c.kind       = KIND_WRITE;
    c.node_index = INDEX_BITS'(idx);
    c.left_rec   = l;
    c.right_rec  = r;
    c.addr_hi    = {$urandom, $urandom};
    c.addr_lo    = {$urandom, $urandom};
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic push_lookup(input logic [63:0] hi, input logic [63:0] lo);
    trie_cmd_t c;
    c.kind       = KIND_LOOKUP;
    c.node_index = INDEX_BITS'($urandom);
    c.left_rec   = REC_IN_BITS'($urandom);
    c.right_rec  = REC_IN_BITS'($urandom);
    c.addr_hi    = hi;
    c.addr_lo    = lo;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // wait until every item is taken and every result is back
  task automatic drain();
    while (cmd_q.size() != 0 || start || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int p_next, input int count);
    int limit;
    int pool_size;
    int c;
    int roll;
    int idx;
    logic [63:0] hi;
    logic [63:0] lo;
    drain();
    @(negedge clk);
    cfg_wr_data <= COUNT_BITS'(n);
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;

    limit = (n > NODE_DEPTH) ? NODE_DEPTH : n;
    pool_q.delete();
    foreach (in_pool[i]) in_pool[i] = 1'b0;
    pool_q.insert(pool_q.size(), 0);
    in_pool[0] = 1'b1;
    pool_size = (limit < 2) ? 1 : $urandom_range(1, (limit < 20) ? limit : 20);
    while (pool_q.size() < pool_size) begin
      c = $urandom_range(0, limit - 1);
      if (!in_pool[c]) begin
        pool_q.insert(pool_q.size(), c);
        in_pool[c] = 1'b1;
      end
    end
    if (limit == NODE_DEPTH && !in_pool[NODE_DEPTH-1]) begin
      pool_q.insert(pool_q.size(), NODE_DEPTH - 1);
      in_pool[NODE_DEPTH-1] = 1'b1;
    end

    // root right record points past the store when the tree size allows it
    foreach (pool_q[i]) begin
      if (pool_q[i] == 0 && n > NODE_DEPTH)
        push_write(0, pick_record(n, p_next), REC_IN_BITS'($urandom_range(NODE_DEPTH, n - 1)));
      else
        push_write(pool_q[i], pick_record(n, p_next), pick_record(n, p_next));
    end

    push_lookup('0, '0);
    push_lookup('1, '1);
    push_lookup(64'h8000_0000_0000_0000, '0);
    push_lookup('0, 64'h1);

    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        case ($urandom_range(0, 3))
          0: begin
            // ipv4 address mapped into ipv6
            hi = '0;
            lo = {32'h0000_ffff, lo[31:0]};
          end
          1: begin
            hi = hi & {$urandom, $urandom} & {$urandom, $urandom};
            lo = lo & {$urandom, $urandom} & {$urandom, $urandom};
          end
          2: begin
            hi = hi | {$urandom, $urandom} | {$urandom, $urandom};
            lo = lo | {$urandom, $urandom} | {$urandom, $urandom};
          end
          default: ;
        endcase
        push_lookup(hi, lo);
      end else if (roll < 90) begin
        idx = pool_q[$urandom_range(0, pool_q.size() - 1)];
        push_write(idx, pick_record(n, p_next), pick_record(n, p_next));
      end else begin
        // nodes outside the tree may hold anything
        idx = $urandom_range(0, NODE_DEPTH - 1);
        if (in_pool[idx])
          push_write(idx, pick_record(n, p_next), pick_record(n, p_next));
        else
          push_write(idx, REC_IN_BITS'($urandom), REC_IN_BITS'($urandom));
      end
    end
  endtask

  // item driver
  always @(negedge clk) begin
    trie_cmd_t cmd;
    if (!start || taken) begin
      taken = 1'b0;
      if (!rst_n || gap_left > 0 || cmd_q.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cmd = cmd_q.pop_front();
        in_kind         <= cmd.kind;
        in_node_index   <= cmd.node_index;
        in_left_record  <= cmd.left_rec;
        in_right_record <= cmd.right_rec;
        in_address_high <= cmd.addr_hi;
        in_address_low  <= cmd.addr_lo;
        start           <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // prediction at acceptance, result check at the strobe
  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n) begin
      if (cfg_wr_en) node_cnt = int'(cfg_wr_data);
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with none outstanding, expected nothing, actual status=%0d offset=%h",
                   $time, out_status, out_data_offset);
          fail_cnt++;
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            fail_cnt++;
          end
          if (out_data_offset !== want.offset) begin
            $display("%0t: data_offset mismatch, expected %h, actual %h",
                     $time, want.offset, out_data_offset);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        taken = 1'b1;
        if (in_kind == KIND_WRITE) begin
          left_mem[in_node_index]  = in_left_record;
          right_mem[in_node_index] = in_right_record;
          n_writes++;
        end else begin
          want = walk_trie(in_address_high, in_address_low);
          result_q.insert(result_q.size(), want);
          n_lookups++;
          if (want.status == STATUS_FOUND) n_found++;
          else if (want.status == STATUS_EMPTY) n_empty++;
          else n_exhausted++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_WRITE;
    in_node_index   = '0;
    in_left_record  = '0;
    in_right_record = '0;
    in_address_high = '0;
    in_address_low  = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // tree size still at its reset value of one
    push_write(0, 24'd1, 24'd2);
    push_lookup('0, '0);                        // empty marker on first bit
    push_lookup(64'h8000_0000_0000_0000, '0);   // offset wraps below zero
    push_write(0, 24'd0, 24'hFF_FFFF);
    push_lookup('0, '0);                        // self loop uses every bit
    push_lookup('1, '1);                        // largest record
    push_lookup('0, 64'h1);                     // data reached on the last bit
    push_write(0, 24'd17, 24'd18);
    push_lookup('0, '0);                        // offset exactly zero
    push_lookup('1, '1);

    run_phase(16384, 95, 160);
    run_phase(0, 0, 160);                       // zero count: record 0 is empty
    run_phase(32767, 90, 160);                  // records past the store
    run_phase(2, 80, 160);
    run_phase($urandom_range(3, 64), 97, 160);
    run_phase($urandom_range(65, 16383), 85, 160);
    run_phase(16385, 60, 160);
    run_phase($urandom_range(1, 16384), 98, 160);
    run_phase(1, 50, 160);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d node writes and %0d lookups over %0d tree size settings",
             n_writes, n_lookups, n_settings + 1);
    $display("lookups ended found %0d, empty %0d, out of address bits %0d",
             n_found, n_empty, n_exhausted);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
